// ===== hdl/spim_pkg.sv =====
// Shared types and constants for the SPI master (modes 0 to 3).
// No dependencies; imported by spim_in_reg, spim_core and the top level.
`default_nettype none
package spim_pkg;

    localparam int unsigned WORD_BITS = 8;
    localparam int unsigned IDX_BITS  = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SELECT   = 2'd1,
        CMD_DESELECT = 2'd2,
        CMD_LOAD     = 2'd3
    } spim_cmd_t;

    // Register map (index = byte address / 4)
    localparam logic REG_CLOCK_MODE = 1'b0;

    typedef struct packed {
        spim_cmd_t              cmd;
        logic [WORD_BITS-1:0]   send_byte;
        logic                   miso_level;
    } spim_item_t;

    typedef struct packed {
        logic                   command_error;
        logic                   busy_res;
        logic                   byte_done;
        logic [WORD_BITS-1:0]   received_byte;
        logic                   cs_n_level;
        logic                   mosi_level;
        logic                   sck_level;
    } spim_result_t;

endpackage
`default_nettype wire

// ===== hdl/spim_in_reg.sv =====
// Input register of the SPI master: holds one accepted item.
// Depends on spim_pkg.
`default_nettype none
module spim_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              drain,
    input  spim_pkg::spim_item_t   item_in,
    output logic                   valid,
    output spim_pkg::spim_item_t   item_out
);
    import spim_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    spim_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (drain)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule
`default_nettype wire

// ===== hdl/spim_core.sv =====
// SPI master state: shift registers, bit counter, pins and clock mode.
// Computes one result per stepped item. Depends on spim_pkg.
`default_nettype none
module spim_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  spim_pkg::spim_item_t   item,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_mode,
    output logic [1:0]             clock_mode,
    output spim_pkg::spim_result_t result
);
    import spim_pkg::*;

    logic [1:0]           mode_reg,   mode_next;
    logic [WORD_BITS-1:0] tx_reg,     tx_next;
    logic [WORD_BITS-1:0] rx_reg,     rx_next;
    logic [IDX_BITS-1:0]  idx_reg,    idx_next;
    logic                 half_reg,   half_next;
    logic                 active_reg, active_next;
    logic                 sck_reg,    sck_next;
    logic                 mosi_reg,   mosi_next;
    logic                 cs_n_reg,   cs_n_next;
    logic                 done;
    logic                 err;
    logic                 cpol;
    logic                 cpha;

    assign cpol = mode_reg[1];
    assign cpha = mode_reg[0];

    always_comb
    begin
        mode_next   = mode_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        idx_next    = idx_reg;
        half_next   = half_reg;
        active_next = active_reg;
        sck_next    = sck_reg;
        mosi_next   = mosi_reg;
        cs_n_next   = cs_n_reg;
        done        = 1'b0;
        err         = 1'b0;

        if (step_en)
        begin
            if (item.cmd == CMD_TICK)
            begin
                if (active_reg)
                begin
                    if (!half_reg)
                    begin
                        // leading edge: drive MOSI, SCK away from idle
                        mosi_next = tx_reg[WORD_BITS-1];
                        sck_next  = ~cpol;
                        if (!cpha)
                        begin
                            rx_next = {rx_reg[WORD_BITS-2:0], item.miso_level};
                        end
                        half_next = 1'b1;
                    end
                    else
                    begin
                        // trailing edge: SCK back to idle
                        sck_next = cpol;
                        if (cpha)
                        begin
                            rx_next = {rx_reg[WORD_BITS-2:0], item.miso_level};
                        end
                        half_next = 1'b0;
                        tx_next   = {tx_reg[WORD_BITS-2:0], 1'b0};
                        if (idx_reg == IDX_BITS'(WORD_BITS - 1))
                        begin
                            done        = 1'b1;
                            active_next = 1'b0;
                            idx_next    = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            else if (active_reg)
            begin
                err = 1'b1;
            end
            else
            begin
                unique case (item.cmd)
                    CMD_SELECT:   cs_n_next = 1'b0;
                    CMD_DESELECT: cs_n_next = 1'b1;
                    CMD_LOAD:
                    begin
                        tx_next     = item.send_byte;
                        rx_next     = '0;
                        idx_next    = '0;
                        half_next   = 1'b0;
                        active_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else if (cfg_we)
        begin
            mode_next = cfg_mode;
            if (!active_reg)
            begin
                sck_next = cfg_mode[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            tx_reg     <= '0;
            rx_reg     <= '0;
            idx_reg    <= '0;
            half_reg   <= 1'b0;
            active_reg <= 1'b0;
            sck_reg    <= 1'b0;
            mosi_reg   <= 1'b0;
            cs_n_reg   <= 1'b1;
        end
        else
        begin
            mode_reg   <= mode_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            idx_reg    <= idx_next;
            half_reg   <= half_next;
            active_reg <= active_next;
            sck_reg    <= sck_next;
            mosi_reg   <= mosi_next;
            cs_n_reg   <= cs_n_next;
        end
    end

    assign clock_mode = mode_reg;

    always_comb
    begin
        result.sck_level     = sck_next;
        result.mosi_level    = mosi_next;
        result.cs_n_level    = cs_n_next;
        result.received_byte = done ? rx_next : '0;
        result.byte_done     = done;
        result.busy_res      = active_next;
        result.command_error = err;
    end

endmodule
`default_nettype wire

// ===== hdl/spi_master_four_modes.sv =====
// Top level of the SPI master for clock modes 0 to 3.
// Depends on spim_pkg, spim_in_reg and spim_core.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tuser = cmd, tdata = send_byte, miso_level
//  m_axis    out  tvalid/tready      tdata = pins, received byte, flags
//  apb       in   psel/penable       register 0 = clock_mode (CPOL bit1, CPHA bit0)
//
// An item waits in the input register until the output register is free; its result
// then sits in the output register. The path between them is the SPI state update,
// one item a cycle while m_tready does not stall. m_tvalid rises once the result is in
// the output register, after the item has passed the input register.
// Reset (rst_n low, asynchronous) gives CPOL/CPHA 0, SCK 0, MOSI 0, CS high, idle.
// A stalled m_tready holds the result; the input register keeps accepting until full.
`default_nettype none
module spi_master_four_modes (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] send_byte, [8] miso_level, rest 0
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] sck_level, [1] mosi_level, [2] cs_n_level,
                                        // [10:3] received_byte, [11] byte_done,
                                        // [12] busy_res, [13] command_error, rest 0
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import spim_pkg::*;

    spim_item_t   s_item;
    spim_item_t   in_item;
    logic         in_valid;
    logic         out_free;
    logic         advance;
    logic         cfg_we;
    logic [1:0]   clock_mode;
    spim_result_t result;

    logic         out_valid_reg;
    logic         out_valid_next;
    spim_result_t out_data_reg;

    // unpack input item
    assign s_item.cmd        = spim_cmd_t'(s_tuser);
    assign s_item.send_byte  = s_tdata[WORD_BITS-1:0];
    assign s_item.miso_level = s_tdata[WORD_BITS];

    // output register frees when empty or being taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid && out_free;
    assign s_tready = !in_valid || out_free;

    spim_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s_tvalid && s_tready),
        .drain    (advance),
        .item_in  (s_item),
        .valid    (in_valid),
        .item_out (in_item)
    );

    // APB: single register, always ready
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CLOCK_MODE);
    assign prdata = (paddr[2] == REG_CLOCK_MODE) ? {30'd0, clock_mode} : 32'd0;

    spim_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .item       (in_item),
        .cfg_we     (cfg_we),
        .cfg_mode   (pwdata[1:0]),
        .clock_mode (clock_mode),
        .result     (result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, out_data_reg};

endmodule
`default_nettype wire

// ===== hdl/spim_checker.sv =====
// Port-level checks for spi_master_four_modes, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module spim_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);

    // a completed byte ends the exchange
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> !m_tdata[12])
        else $error("byte_done with busy still set");

    // rejected commands only happen mid-exchange
    a_err_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[12] && !m_tdata[11])
        else $error("command_error outside an exchange");

    // received byte is zero unless a byte completes
    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[11] |-> m_tdata[10:3] == 8'd0)
        else $error("received_byte nonzero without byte_done");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind spi_master_four_modes spim_checker u_spim_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
